@@ design/pdll_pkg.sv @@
// shared types and codes of the positional linked list block
package pdll_pkg;

  // operation codes carried by the cmd field
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    accept;    // latch the transaction and restart the walk at the header
    logic    step;      // advance the walk by one node
    logic    ins_link;  // write value and forward link of the new node
    logic    ins_fix;   // splice the new node behind its predecessor
    logic    del_fix;   // unlink the node behind the walk position and free it
    logic    finish;    // capture the result registers
    status_e st;        // status to capture
    logic    rd_sel;    // capture the value read for the node behind the walk position
    logic    found_sel; // capture the locate position
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic bad_pos;   // position out of range for the incoming command
    logic full;      // no free node left
    logic walk_end;  // walk has taken its planned number of steps
    logic match;     // locate compare hit on the node behind the walk
  } dp_stat_t;

endpackage

@@ design/positional_doubly_linked_list_top.sv @@
// top level of the positional linked list block
// Usage: a circular list of values kept in a fixed pool of CAPACITY nodes behind a
// header node. Drive cmd_i, position_i and item_value_i with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Commands: insert at position 1..length+1, delete and get at 1..length, locate.
// Each transaction gives one result, shown for exactly one cycle with done_o high:
// status_o, read_value_o, found_position_o, list_length_o and list_empty_o.
// A range or pool-full error is reported without a walk; insert, delete and get
// walk to the given position, and locate walks to the hit or, on a miss, over the
// whole list. The walk follows the forward link memory one node per cycle. busy
// is low again in the done_o cycle, so a new transaction can be taken there.
// The receiver cannot stall: the result is gone after its cycle. Reset empties
// the list at once; no clearing pass runs, and node memories are only read
// after they are written.
module positional_doubly_linked_list_top #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_value_o,
  output logic [8:0]         found_position_o,
  output logic [8:0]         list_length_o,
  output logic               list_empty_o
);
  import pdll_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // controller
  pdll_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .stat_i   (dp_stat),
    .dp_cmd_o (dp_cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // datapath
  pdll_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dp_cmd_i         (dp_cmd),
    .stat_o           (dp_stat),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_position_o (found_position_o),
    .list_length_o    (list_length_o),
    .list_empty_o     (list_empty_o)
  );

`ifndef SYNTHESIS
  // a result strobe never overlaps a transaction in flight
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // position zero on a positional command fails on the next cycle
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && position_i == 10'd0 && cmd_i != OP_LOCATE)
      |=> (done_o && status_o == ST_RANGE))
    else $error("position zero not rejected");

  // pool full is reported for inserts only
  a_full_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i != OP_INSERT) |=> !(done_o && status_o == ST_FULL))
    else $error("pool full reported for a non insert");

  // a failed transaction leaves the length unchanged
  a_fail_keeps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> $stable(list_length_o))
    else $error("failed transaction changed the length");
`endif

endmodule

@@ design/pdll_ctrl.sv @@
// controller state machine of the positional linked list block
module pdll_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         cmd_i,
  input  pdll_pkg::dp_stat_t stat_i,
  output pdll_pkg::dp_cmd_t  dp_cmd_o,
  output logic               busy,
  output logic               done_o
);
  import pdll_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_WALK    = 2'd1;
  localparam logic [1:0] S_INS_FIX = 2'd2;

  logic [1:0] state_q, state_d;
  op_e        op_q, op_d;
  logic       done_q;

  // next state and datapath commands
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    dp_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = op_e'(cmd_i);
          if (stat_i.bad_pos) begin
            dp_cmd_o.finish = 1'b1;
            dp_cmd_o.st     = ST_RANGE;
          end else if (op_e'(cmd_i) == OP_INSERT && stat_i.full) begin
            dp_cmd_o.finish = 1'b1;
            dp_cmd_o.st     = ST_FULL;
          end else begin
            dp_cmd_o.accept = 1'b1;
            state_d         = S_WALK;
          end
        end
      end
      S_WALK: begin
        case (op_q)
          OP_INSERT: begin
            if (stat_i.walk_end) begin
              dp_cmd_o.ins_link = 1'b1;
              state_d           = S_INS_FIX;
            end else begin
              dp_cmd_o.step = 1'b1;
            end
          end
          OP_DELETE: begin
            if (stat_i.walk_end) begin
              dp_cmd_o.del_fix = 1'b1;
              dp_cmd_o.finish  = 1'b1;
              dp_cmd_o.st      = ST_OK;
              dp_cmd_o.rd_sel  = 1'b1;
              state_d          = S_IDLE;
            end else begin
              dp_cmd_o.step = 1'b1;
            end
          end
          OP_GET: begin
            if (stat_i.walk_end) begin
              dp_cmd_o.finish = 1'b1;
              dp_cmd_o.st     = ST_OK;
              dp_cmd_o.rd_sel = 1'b1;
              state_d         = S_IDLE;
            end else begin
              dp_cmd_o.step = 1'b1;
            end
          end
          OP_LOCATE: begin
            if (stat_i.match) begin
              dp_cmd_o.finish    = 1'b1;
              dp_cmd_o.st        = ST_OK;
              dp_cmd_o.found_sel = 1'b1;
              state_d            = S_IDLE;
            end else if (stat_i.walk_end) begin
              dp_cmd_o.finish = 1'b1;
              dp_cmd_o.st     = ST_OK;
              state_d         = S_IDLE;
            end else begin
              dp_cmd_o.step = 1'b1;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_INS_FIX: begin
        dp_cmd_o.ins_fix = 1'b1;
        dp_cmd_o.finish  = 1'b1;
        dp_cmd_o.st      = ST_OK;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, operation and result strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INSERT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      done_q  <= dp_cmd_o.finish;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ design/pdll_dpath.sv @@
// datapath of the positional linked list block: node pool, links, free stack, walker
module pdll_dpath #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdll_pkg::dp_cmd_t  dp_cmd_i,
  output pdll_pkg::dp_stat_t stat_o,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_value_o,
  output logic [8:0]         found_position_o,
  output logic [8:0]         list_length_o,
  output logic               list_empty_o
);
  import pdll_pkg::*;

  localparam int NW  = $clog2(CAPACITY);          // node index
  localparam int LW  = $clog2(CAPACITY + 1);      // link, header included; also counts
  localparam int IW  = $clog2(CAPACITY + 2);      // walk step counter
  localparam int PW  = ((IW > 10) ? IW : 10) + 1; // position compare width
  localparam int OW  = (IW > 9) ? IW : 9;
  localparam int CWW = (LW > 9) ? LW : 9;
  localparam logic [LW-1:0] HEAD = LW'(CAPACITY);

  // storage
  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
  logic [LW-1:0]          link_mem [CAPACITY];
  logic [NW-1:0]          free_mem [CAPACITY];

  logic [LW-1:0] count_q;
  logic [LW-1:0] head_next_q;
  logic [LW-1:0] sp_q;
  logic [LW-1:0] fresh_q;

  // walker
  logic [LW-1:0]          cur_q, prev_q, prev2_q;
  logic                   from_mem_q;
  logic [IW-1:0]          idx_q, target_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [LW-1:0]          link_rd_q;
  logic [VALUE_WIDTH-1:0] val_rd_q;
  logic [NW-1:0]          free_rd_q;

  // results
  status_e                status_q;
  logic [VALUE_WIDTH-1:0] rd_q;
  logic [IW-1:0]          found_q;

  logic [LW-1:0] cur_w;
  logic          cur_is_head;
  logic [NW-1:0] nn;
  logic [LW-1:0] sp_m1;
  logic [PW-1:0] pos_w, cnt_w;
  logic [PW-1:0] target_w;
  logic          bad_pos_w;
  logic          link_we;
  logic [NW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;
  logic [OW-1:0] found_wide;
  logic [CWW-1:0] len_wide;

  // current walk node: straight from the link read port while stepping
  assign cur_w       = from_mem_q ? link_rd_q : cur_q;
  assign cur_is_head = (cur_w == HEAD);

  // node to allocate: top of the free stack, else a never used node
  assign sp_m1 = sp_q - LW'(1);
  assign nn    = (sp_q != '0) ? free_rd_q : fresh_q[NW-1:0];

  // range checks and walk length for the incoming transaction
  assign pos_w = PW'(position_i);
  assign cnt_w = PW'(count_q);
  always_comb begin
    bad_pos_w = 1'b0;
    target_w  = pos_w + PW'(1);
    case (op_e'(cmd_i))
      OP_INSERT: begin
        bad_pos_w = (pos_w == '0) || (pos_w > cnt_w + PW'(1));
        target_w  = pos_w;
      end
      OP_DELETE, OP_GET: begin
        bad_pos_w = (pos_w == '0) || (pos_w > cnt_w);
        target_w  = pos_w + PW'(1);
      end
      OP_LOCATE: begin
        target_w = cnt_w + PW'(1);
      end
      default: begin
        bad_pos_w = 1'b0;
      end
    endcase
  end

  assign stat_o.bad_pos  = bad_pos_w;
  assign stat_o.full     = (count_q == LW'(CAPACITY));
  assign stat_o.walk_end = (idx_q == target_q);
  assign stat_o.match    = (idx_q >= IW'(2)) && (val_rd_q == val_q);

  // walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_mem_q <= 1'b0;
      idx_q      <= '0;
    end else if (dp_cmd_i.accept) begin
      from_mem_q <= 1'b0;
      idx_q      <= '0;
    end else if (dp_cmd_i.step) begin
      from_mem_q <= !cur_is_head;
      idx_q      <= idx_q + IW'(1);
    end else begin
      from_mem_q <= 1'b0;
    end
  end

  // walk payload: node, the two nodes behind it, transaction value
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.accept) begin
      cur_q    <= HEAD;
      target_q <= IW'(target_w);
      val_q    <= VALUE_WIDTH'($unsigned(item_value_i));
    end else if (dp_cmd_i.step) begin
      prev2_q <= prev_q;
      prev_q  <= cur_w;
      cur_q   <= cur_is_head ? head_next_q : cur_w;
    end else begin
      cur_q <= cur_w;
    end
  end

  // link write port
  always_comb begin
    link_we    = 1'b0;
    link_waddr = nn;
    link_wdata = cur_w;
    if (dp_cmd_i.ins_link) begin
      link_we = 1'b1;
    end else if (dp_cmd_i.ins_fix && prev_q != HEAD) begin
      link_we    = 1'b1;
      link_waddr = prev_q[NW-1:0];
      link_wdata = LW'(nn);
    end else if (dp_cmd_i.del_fix && prev2_q != HEAD) begin
      link_we    = 1'b1;
      link_waddr = prev2_q[NW-1:0];
    end
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[cur_w[NW-1:0]];
  end

  // value memory
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.ins_link) begin
      val_mem[nn] <= val_q;
    end
    val_rd_q <= val_mem[cur_w[NW-1:0]];
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.del_fix) begin
      free_mem[sp_q[NW-1:0]] <= prev_q[NW-1:0];
    end
    free_rd_q <= free_mem[sp_m1[NW-1:0]];
  end

  // header link, element count and allocation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_next_q <= HEAD;
      count_q     <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
    end else if (dp_cmd_i.ins_fix) begin
      if (prev_q == HEAD) begin
        head_next_q <= LW'(nn);
      end
      count_q <= count_q + LW'(1);
      if (sp_q != '0) begin
        sp_q <= sp_m1;
      end else begin
        fresh_q <= fresh_q + LW'(1);
      end
    end else if (dp_cmd_i.del_fix) begin
      if (prev2_q == HEAD) begin
        head_next_q <= cur_w;
      end
      count_q <= count_q - LW'(1);
      sp_q    <= sp_q + LW'(1);
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.finish) begin
      status_q <= dp_cmd_i.st;
      rd_q     <= dp_cmd_i.rd_sel ? val_rd_q : '0;
      found_q  <= dp_cmd_i.found_sel ? (idx_q - IW'(1)) : '0;
    end
  end

  // result ports
  assign found_wide       = OW'(found_q);
  assign len_wide         = CWW'(count_q);
  assign status_o         = status_q;
  assign read_value_o     = $signed(32'(rd_q));
  assign found_position_o = found_wide[8:0];
  assign list_length_o    = len_wide[8:0];
  assign list_empty_o     = (count_q == '0);

endmodule
